>>> rtl/midpoint_ellipse_rasterizer_unit_defines.svh
// assertion macros for the midpoint ellipse rasterizer
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_UNIT_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MER_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mer_pkg.sv
// shared types, constants and microcode rom of the ellipse rasterizer
`timescale 1ns / 1ps

package mer_pkg;

	// widths fixed by the field and state formats
	localparam int COORD_BITS_DEF = 10;
	localparam int DEC_W = 46;
	localparam int STEP_W = 32;
	localparam int OUT_W = 12;

	// register reset values
	localparam int RST_CENTER_X = 300;
	localparam int RST_CENTER_Y = 200;
	localparam int RST_RADIUS_X = 200;
	localparam int RST_RADIUS_Y = 100;

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CENTER_X = 2'd0;
	localparam reg_idx_t REG_CENTER_Y = 2'd1;
	localparam reg_idx_t REG_RADIUS_X = 2'd2;
	localparam reg_idx_t REG_RADIUS_Y = 2'd3;

	// microcode addresses
	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;
	localparam upc_t UA_IDLE       = 4'd0;
	localparam upc_t UA_SQ_RX      = 4'd1;
	localparam upc_t UA_SQ_RY      = 4'd2;
	localparam upc_t UA_PROD       = 4'd3;
	localparam upc_t UA_WALK_CHK   = 4'd4;
	localparam upc_t UA_POINTS     = 4'd5;
	localparam upc_t UA_RESTART    = 4'd6;
	localparam upc_t UA_SETTLE_CHK = 4'd7;
	localparam upc_t UA_TX         = 4'd8;
	localparam upc_t UA_YM         = 4'd9;
	localparam upc_t UA_RR         = 4'd10;
	localparam upc_t UA_ACC0       = 4'd11;
	localparam upc_t UA_ACC1       = 4'd12;
	localparam upc_t UA_DEC2       = 4'd13;
	localparam upc_t UA_END        = 4'd14;

	// multiplier operand pairs
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_RX2_RY,
		MUL_TX_TX,
		MUL_YM_YM,
		MUL_RX2_RY2,
		MUL_RY2_T,
		MUL_RX2_U
	} mul_sel_t;

	// product write-back targets
	typedef enum logic [3:0] {
		WR_NONE,
		WR_RX2,
		WR_RY2,
		WR_T,
		WR_U,
		WR_ACC_NEG4,
		WR_ACC_ADD,
		WR_DEC_ADD4,
		WR_RESTART
	} wr_sel_t;

	typedef enum logic [0:0] {
		ACT_NONE,
		ACT_POINTS
	} act_t;

	// sequencer branch kinds
	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_ALWAYS,
		JMP_IF_RESTART,
		JMP_IF_NO_WALK,
		JMP_IF_NO_SETTLE,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic     take_in;
		mul_sel_t mul;
		wr_sel_t  wr;
		act_t     act;
		jmp_t     jmp;
		upc_t     target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		logic     accept;
		logic     load_out;
		mul_sel_t mul;
		wr_sel_t  wr;
		act_t     act;
	} dp_ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic is_restart;
		logic walk_on;
		logic settle;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [2:0] {
		PH_DONE    = 3'b001,
		PH_REGION1 = 3'b010,
		PH_REGION2 = 3'b100
	} phase_t;

	typedef struct packed {
		logic                    valid_res;
		logic signed [OUT_W-1:0] quad1_x;
		logic signed [OUT_W-1:0] quad1_y;
		logic signed [OUT_W-1:0] quad2_x;
		logic signed [OUT_W-1:0] quad2_y;
		logic signed [OUT_W-1:0] quad3_x;
		logic signed [OUT_W-1:0] quad3_y;
		logic signed [OUT_W-1:0] quad4_x;
		logic signed [OUT_W-1:0] quad4_y;
		logic                    last_point;
	} pts_t;

	function automatic uword_t uw(logic take_in, mul_sel_t mul, wr_sel_t wr, act_t act,
			jmp_t jmp, upc_t target);
		uword_t w;
		w.take_in = take_in;
		w.mul     = mul;
		w.wr      = wr;
		w.act     = act;
		w.jmp     = jmp;
		w.target  = target;
		return w;
	endfunction

	// control store: squares of the radii each request, then walk or restart,
	// then the region-2 decision set-up when the slope crosses
	function automatic uword_t ucode(upc_t addr);
		uword_t w;
		case (addr)
			UA_IDLE:       w = uw(1'b1, MUL_NONE, WR_NONE, ACT_NONE, JMP_WAIT_IN, UA_IDLE);
			UA_SQ_RX:      w = uw(1'b0, MUL_RX_RX, WR_NONE, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_SQ_RY:      w = uw(1'b0, MUL_RY_RY, WR_RX2, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_PROD:       w = uw(1'b0, MUL_RX2_RY, WR_RY2, ACT_NONE, JMP_IF_RESTART,
						UA_RESTART);
			UA_WALK_CHK:   w = uw(1'b0, MUL_NONE, WR_NONE, ACT_NONE, JMP_IF_NO_WALK, UA_END);
			UA_POINTS:     w = uw(1'b0, MUL_NONE, WR_NONE, ACT_POINTS, JMP_ALWAYS,
						UA_SETTLE_CHK);
			UA_RESTART:    w = uw(1'b0, MUL_NONE, WR_RESTART, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_SETTLE_CHK: w = uw(1'b0, MUL_NONE, WR_NONE, ACT_NONE, JMP_IF_NO_SETTLE, UA_END);
			UA_TX:         w = uw(1'b0, MUL_TX_TX, WR_NONE, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_YM:         w = uw(1'b0, MUL_YM_YM, WR_T, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_RR:         w = uw(1'b0, MUL_RX2_RY2, WR_U, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_ACC0:       w = uw(1'b0, MUL_RY2_T, WR_ACC_NEG4, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_ACC1:       w = uw(1'b0, MUL_RX2_U, WR_ACC_ADD, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_DEC2:       w = uw(1'b0, MUL_NONE, WR_DEC_ADD4, ACT_NONE, JMP_NEXT, UA_IDLE);
			UA_END:        w = uw(1'b0, MUL_NONE, WR_NONE, ACT_NONE, JMP_WAIT_OUT, UA_IDLE);
			default:       w = uw(1'b0, MUL_NONE, WR_NONE, ACT_NONE, JMP_ALWAYS, UA_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/mer_if.sv
// request and point-set channel interfaces
`timescale 1ns / 1ps

interface mer_cmd_if;
	import mer_pkg::*;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mer_pts_if;
	import mer_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    valid_res;
	logic signed [OUT_W-1:0] quad1_x;
	logic signed [OUT_W-1:0] quad1_y;
	logic signed [OUT_W-1:0] quad2_x;
	logic signed [OUT_W-1:0] quad2_y;
	logic signed [OUT_W-1:0] quad3_x;
	logic signed [OUT_W-1:0] quad3_y;
	logic signed [OUT_W-1:0] quad4_x;
	logic signed [OUT_W-1:0] quad4_y;
	logic                    last_point;

	modport source (output valid, output valid_res, output quad1_x, output quad1_y,
		output quad2_x, output quad2_y, output quad3_x, output quad3_y,
		output quad4_x, output quad4_y, output last_point, input ready);
	modport sink (input valid, input valid_res, input quad1_x, input quad1_y,
		input quad2_x, input quad2_y, input quad3_x, input quad3_y,
		input quad4_x, input quad4_y, input last_point, output ready);
endinterface

>>> rtl/midpoint_ellipse_rasterizer_unit.sv
// Midpoint ellipse rasterizer top level: config registers, sequencer and datapath.
// A request restarts the walk or advances it by one point set; an empty result is returned
// for a restart or when the walk is finished. Region 2 is set up when the slope crosses.
// The shared multiplier forms rx^2, ry^2 and rx^2*ry each request, and five more products
// for region 2. A new request is taken only in idle, after the last result is loaded for output.
// Reset restores the register defaults, marks the walk finished and empties the output.
`include "midpoint_ellipse_rasterizer_unit_defines.svh"
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  mer_pkg::reg_idx_t     cfg_idx,
	input  logic [COORD_BITS-1:0] cfg_data,
	mer_cmd_if.sink               cmd,
	mer_pts_if.source             pts
);
	import mer_pkg::*;

	logic [COORD_BITS-1:0] center_x_q;
	logic [COORD_BITS-1:0] center_y_q;
	logic [COORD_BITS-1:0] radius_x_q;
	logic [COORD_BITS-1:0] radius_y_q;
	dp_ctl_t               ctl;
	dp_stat_t              stat;
	logic                  out_valid;
	pts_t                  out_pts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= COORD_BITS'(RST_CENTER_X);
			center_y_q <= COORD_BITS'(RST_CENTER_Y);
			radius_x_q <= COORD_BITS'(RST_RADIUS_X);
			radius_y_q <= COORD_BITS'(RST_RADIUS_Y);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_RADIUS_X: radius_x_q <= cfg_data;
				REG_RADIUS_Y: radius_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath
	mer_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.radius_x    (radius_x_q),
		.radius_y    (radius_y_q),
		.cmd_restart (cmd.restart),
		.ctl         (ctl),
		.out_ready   (pts.ready),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_pts     (out_pts)
	);

	// result channel
	assign pts.valid      = out_valid;
	assign pts.valid_res  = out_pts.valid_res;
	assign pts.quad1_x    = out_pts.quad1_x;
	assign pts.quad1_y    = out_pts.quad1_y;
	assign pts.quad2_x    = out_pts.quad2_x;
	assign pts.quad2_y    = out_pts.quad2_y;
	assign pts.quad3_x    = out_pts.quad3_x;
	assign pts.quad3_y    = out_pts.quad3_y;
	assign pts.quad4_x    = out_pts.quad4_x;
	assign pts.quad4_y    = out_pts.quad4_y;
	assign pts.last_point = out_pts.last_point;

	// checks
	`MER_ASSERT_NEXT(a_one_request, cmd.valid && cmd.ready, !cmd.ready, "request taken while busy")
	`MER_ASSERT_NEXT(a_no_stray_out, !pts.valid && !ctl.load_out, !pts.valid, "result without load")
	`MER_ASSERT_SAME(a_last_valid, pts.valid && pts.last_point, pts.valid_res, "last set not valid")
	`MER_ASSERT_SAME(a_empty_zero, pts.valid && !pts.valid_res, pts.quad1_x == '0 && !pts.last_point, "empty result not cleared")

endmodule

>>> rtl/mer_ctrl.sv
// microcode sequencer: program counter, control store and branch logic
`timescale 1ns / 1ps

module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  mer_pkg::dp_stat_t stat,
	output mer_pkg::dp_ctl_t  ctl
);
	import mer_pkg::*;

	upc_t   upc_q;
	upc_t   upc_nxt;
	upc_t   upc_inc;
	uword_t cw;
	logic   accept;

	// current control word
	assign cw        = ucode(upc_q);
	assign cmd_ready = cw.take_in;
	assign accept    = cw.take_in & cmd_valid;
	assign upc_inc   = upc_q + upc_t'(1);

	// branch resolution
	always_comb begin
		case (cw.jmp)
			JMP_NEXT:         upc_nxt = upc_inc;
			JMP_WAIT_IN:      upc_nxt = accept ? upc_inc : upc_q;
			JMP_ALWAYS:       upc_nxt = cw.target;
			JMP_IF_RESTART:   upc_nxt = stat.is_restart ? cw.target : upc_inc;
			JMP_IF_NO_WALK:   upc_nxt = stat.walk_on ? upc_inc : cw.target;
			JMP_IF_NO_SETTLE: upc_nxt = stat.settle ? upc_inc : cw.target;
			JMP_WAIT_OUT:     upc_nxt = stat.out_free ? UA_IDLE : upc_q;
			default:          upc_nxt = UA_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ctl.accept   = accept;
		ctl.load_out = (cw.jmp == JMP_WAIT_OUT) && stat.out_free;
		ctl.mul      = cw.mul;
		ctl.wr       = cw.wr;
		ctl.act      = cw.act;
	end

	// program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

>>> rtl/mer_dp.sv
// datapath: shared multiplier, walk state, decision update and result registers
`timescale 1ns / 1ps

module mer_dp #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-1:0] radius_x,
	input  logic [COORD_BITS-1:0] radius_y,
	input  logic                  cmd_restart,
	input  mer_pkg::dp_ctl_t      ctl,
	input  logic                  out_ready,
	output mer_pkg::dp_stat_t     stat,
	output logic                  out_valid,
	output mer_pkg::pts_t         out_pts
);
	import mer_pkg::*;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int MUL_W  = 2 * COORD_BITS + 2;
	localparam int PROD_W = 2 * MUL_W;

	logic [COORD_BITS-1:0] walk_x_q;
	logic [COORD_BITS-1:0] walk_y_q;
	logic [STEP_W-1:0]     step_dx_q;
	logic [STEP_W-1:0]     step_dy_q;
	logic [DEC_W-1:0]      dec_q;
	logic [DEC_W-1:0]      acc_q;
	logic [DEC_W-1:0]      prod_q;
	logic [SQ_W-1:0]       rx2_q;
	logic [SQ_W-1:0]       ry2_q;
	logic [MUL_W-1:0]      t_q;
	logic [MUL_W-1:0]      u_q;
	phase_t                phase_q;
	logic                  restart_q;
	logic                  out_valid_q;
	pts_t                  st_q;
	pts_t                  out_q;

	logic [COORD_BITS:0]   tx;
	logic [COORD_BITS-1:0] ym;
	logic [MUL_W-1:0]      mul_a;
	logic [MUL_W-1:0]      mul_b;
	logic [PROD_W-1:0]     mul_full;

	logic [STEP_W-1:0]     dx_inc;
	logic [STEP_W-1:0]     dy_dec;
	logic [DEC_W-1:0]      dx_ry4;
	logic [DEC_W-1:0]      dx_rx4;
	logic [DEC_W-1:0]      rx4;
	logic [DEC_W-1:0]      dy4;
	logic                  dec_neg;
	logic                  dec_pos;
	logic                  y_zero;

	logic [OUT_W-1:0]      cx_o;
	logic [OUT_W-1:0]      cy_o;
	logic [OUT_W-1:0]      x_o;
	logic [OUT_W-1:0]      y_o;
	pts_t                  pts_now;

	// region-2 set-up terms: 2x+1 and |y-1|
	assign y_zero = (walk_y_q == '0);
	assign tx     = {walk_x_q, 1'b1};
	assign ym     = y_zero ? COORD_BITS'(1) : walk_y_q - COORD_BITS'(1);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.mul)
			MUL_RX_RX: begin
				mul_a = MUL_W'(radius_x);
				mul_b = MUL_W'(radius_x);
			end
			MUL_RY_RY: begin
				mul_a = MUL_W'(radius_y);
				mul_b = MUL_W'(radius_y);
			end
			MUL_RX2_RY: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = MUL_W'(radius_y);
			end
			MUL_TX_TX: begin
				mul_a = MUL_W'(tx);
				mul_b = MUL_W'(tx);
			end
			MUL_YM_YM: begin
				mul_a = MUL_W'(ym);
				mul_b = MUL_W'(ym);
			end
			MUL_RX2_RY2: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = MUL_W'(ry2_q);
			end
			MUL_RY2_T: begin
				mul_a = MUL_W'(ry2_q);
				mul_b = t_q;
			end
			MUL_RX2_U: begin
				mul_a = MUL_W'(rx2_q);
				mul_b = u_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register, kept modulo the decision width
	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= DEC_W'(mul_full);
	end

	// per-step increments
	assign dx_inc  = step_dx_q + (STEP_W'(ry2_q) << 1);
	assign dy_dec  = step_dy_q - (STEP_W'(rx2_q) << 1);
	assign dx_ry4  = (DEC_W'(dx_inc) + DEC_W'(ry2_q)) << 2;
	assign dx_rx4  = (DEC_W'(dx_inc) + DEC_W'(rx2_q)) << 2;
	assign rx4     = DEC_W'(rx2_q) << 2;
	assign dy4     = DEC_W'(dy_dec) << 2;
	assign dec_neg = dec_q[DEC_W-1];
	assign dec_pos = !dec_neg && (dec_q != '0);

	// four symmetric points, wrapped to the output width
	assign cx_o = OUT_W'(center_x);
	assign cy_o = OUT_W'(center_y);
	assign x_o  = OUT_W'(walk_x_q);
	assign y_o  = OUT_W'(walk_y_q);

	always_comb begin
		pts_now.valid_res  = 1'b1;
		pts_now.quad1_x    = cx_o + x_o;
		pts_now.quad1_y    = cy_o + y_o;
		pts_now.quad2_x    = cx_o + x_o;
		pts_now.quad2_y    = cy_o - y_o;
		pts_now.quad3_x    = cx_o - x_o;
		pts_now.quad3_y    = cy_o - y_o;
		pts_now.quad4_x    = cx_o - x_o;
		pts_now.quad4_y    = cy_o + y_o;
		pts_now.last_point = (phase_q == PH_REGION2) && y_zero;
	end

	// walk phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
		end else if (ctl.wr == WR_RESTART) begin
			phase_q <= PH_REGION1;
		end else if (ctl.wr == WR_DEC_ADD4) begin
			phase_q <= PH_REGION2;
		end else if (ctl.act == ACT_POINTS && phase_q == PH_REGION2 && y_zero) begin
			phase_q <= PH_DONE;
		end
	end

	// product write-back and walk update
	always_ff @(posedge clk) begin
		case (ctl.wr)
			WR_RX2:      rx2_q <= SQ_W'(prod_q);
			WR_RY2:      ry2_q <= SQ_W'(prod_q);
			WR_T:        t_q <= MUL_W'(prod_q);
			WR_U:        u_q <= MUL_W'(prod_q);
			WR_ACC_NEG4: acc_q <= '0 - (prod_q << 2);
			WR_ACC_ADD:  acc_q <= acc_q + prod_q;
			WR_DEC_ADD4: dec_q <= acc_q + (prod_q << 2);
			WR_RESTART: begin
				walk_x_q  <= '0;
				walk_y_q  <= radius_y;
				step_dx_q <= '0;
				step_dy_q <= STEP_W'(prod_q << 1);
				dec_q     <= DEC_W'(rx2_q) + (DEC_W'(ry2_q) << 2) - (prod_q << 2);
			end
			default: begin
			end
		endcase
		if (ctl.act == ACT_POINTS) begin
			if (phase_q == PH_REGION1) begin
				walk_x_q  <= walk_x_q + COORD_BITS'(1);
				step_dx_q <= dx_inc;
				if (dec_neg) begin
					dec_q <= dec_q + dx_ry4;
				end else begin
					walk_y_q  <= walk_y_q - COORD_BITS'(1);
					step_dy_q <= dy_dec;
					dec_q     <= dec_q + dx_ry4 - dy4;
				end
			end else if (phase_q == PH_REGION2 && !y_zero) begin
				walk_y_q  <= walk_y_q - COORD_BITS'(1);
				step_dy_q <= dy_dec;
				if (dec_pos) begin
					dec_q <= dec_q + rx4 - dy4;
				end else begin
					walk_x_q  <= walk_x_q + COORD_BITS'(1);
					step_dx_q <= dx_inc;
					dec_q     <= dec_q + dx_rx4 - dy4;
				end
			end
		end
	end

	// staged result: zero on a new request, points when the walk emits
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			st_q <= '0;
		end else if (ctl.act == ACT_POINTS) begin
			st_q <= pts_now;
		end
	end

	// request kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				restart_q <= cmd_restart;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= st_q;
		end
	end

	// status to the sequencer
	always_comb begin
		stat.is_restart = restart_q;
		stat.walk_on    = (phase_q != PH_DONE);
		stat.settle     = (phase_q == PH_REGION1) && !(step_dx_q < step_dy_q);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_pts   = out_q;

endmodule
